@@ src/epoch_seconds_calendar_converter_top_defines.svh @@
// Assertion macros for the epoch seconds calendar converter.
// Expects signals named clk and rst_n in the scope where a macro is used.
// No other dependencies.
`ifndef EPOCH_SECONDS_CALENDAR_CONVERTER_TOP_DEFINES_SVH
`define EPOCH_SECONDS_CALENDAR_CONVERTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ESCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/escc_pkg.sv @@
// Shared types, constants and calendar helpers of the epoch seconds calendar converter.
// Used by escc_div, epoch_seconds_calendar_converter_top and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package escc_pkg;

    localparam int YEAR_SPAN_DEF = 256;

    localparam logic [11:0] BASE_YEAR_RST = 12'd1990;

    localparam logic [1:0] OP_TO_DATE  = 2'd0;
    localparam logic [1:0] OP_TO_SECS  = 2'd1;
    localparam logic [1:0] OP_NEXT_DAY = 2'd2;
    localparam logic [1:0] OP_PREV_DAY = 2'd3;

    localparam logic [16:0] DAY_SECONDS  = 17'd86400;
    localparam logic [16:0] HOUR_SECONDS = 17'd3600;
    localparam logic [16:0] MIN_SECONDS  = 17'd60;
    localparam logic [16:0] WEEK_DAYS    = 17'd7;
    localparam logic [16:0] CENTURY      = 17'd100;
    localparam logic [16:0] QUAD_CENTURY = 17'd400;

    // Reciprocals are floor(2^32 / divisor).
    localparam logic [31:0] DAY_RECIP          = 32'd49710;
    localparam logic [31:0] HOUR_RECIP         = 32'd1193046;
    localparam logic [31:0] MIN_RECIP          = 32'd71582788;
    localparam logic [31:0] WEEK_RECIP         = 32'd613566756;
    localparam logic [31:0] CENTURY_RECIP      = 32'd42949672;
    localparam logic [31:0] QUAD_CENTURY_RECIP = 32'd10737418;

    localparam logic [3:0] LAST_MONTH = 4'd12;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] epoch_seconds;
        logic [11:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
    } escc_req_t;

    typedef struct packed {
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [31:0] total_seconds;
        logic [2:0]  weekday;
    } escc_rsp_t;

    typedef struct packed {
        logic        go;
        logic [31:0] dividend;
        logic [16:0] divisor;
        logic [31:0] recip;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [16:0] remainder;
    } div_rsp_t;

    // Month length; anything outside 1 to 12 is a one-day month.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                                  len = 5'd1;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ src/escc_div.sv @@
// Shared constant divider for the calendar converter: a reciprocal multiply, a back
// multiply and one correction step in the phases PH_MUL, PH_BACK and PH_FIX, then done.
// Depends on escc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module escc_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire escc_pkg::div_cmd_t cmd,
    output escc_pkg::div_rsp_t      rsp
);

    localparam logic [1:0] PH_MUL  = 2'd0;
    localparam logic [1:0] PH_BACK = 2'd1;
    localparam logic [1:0] PH_FIX  = 2'd2;

    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] rcp_reg, rcp_next;
    logic [16:0] dsr_reg, dsr_next;
    logic [31:0] quot_reg, quot_next;
    logic [17:0] part_reg, part_next;
    logic [16:0] rem_reg, rem_next;
    logic [1:0]  phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [63:0] product;
    logic [31:0] back;
    logic [17:0] fix_diff;

    // The estimate from the truncated reciprocal is the true quotient or one below it.
    always_comb
    begin
        product    = 64'(dvd_reg) * 64'(rcp_reg);
        back       = dvd_reg - quot_reg * 32'(dsr_reg);
        fix_diff   = part_reg - {1'b0, dsr_reg};
        dvd_next   = dvd_reg;
        rcp_next   = rcp_reg;
        dsr_next   = dsr_reg;
        quot_next  = quot_reg;
        part_next  = part_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (cmd.go)
        begin
            dvd_next   = cmd.dividend;
            rcp_next   = cmd.recip;
            dsr_next   = cmd.divisor;
            phase_next = PH_MUL;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            case (phase_reg)
                PH_MUL:
                begin
                    quot_next  = product[63:32];
                    phase_next = PH_BACK;
                end
                PH_BACK:
                begin
                    part_next  = back[17:0];
                    phase_next = PH_FIX;
                end
                PH_FIX:
                begin
                    if (part_reg >= {1'b0, dsr_reg})
                    begin
                        quot_next = quot_reg + 32'd1;
                        rem_next  = fix_diff[16:0];
                    end
                    else
                    begin
                        rem_next = part_reg[16:0];
                    end
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_MUL;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rcp_reg  <= rcp_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
        part_reg <= part_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        rsp.done      = done_reg;
        rsp.quotient  = quot_reg;
        rsp.remainder = rem_reg;
    end

endmodule

`default_nettype wire

@@ src/epoch_seconds_calendar_converter_top.sv @@
// Top level of the epoch seconds calendar converter: sequencer, calendar datapath
// and the base year register. Depends on escc_pkg, escc_div and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "epoch_seconds_calendar_converter_top_defines.svh"

// Channel    | Ports                           | Transfer
// -----------+---------------------------------+------------------------------------------
// request    | start, busy, req                | start high while busy low
// result     | done, rsp                       | done high for one cycle, always taken
// base year  | cfg_valid, cfg_ready, cfg_data  | cfg_valid and cfg_ready both high
//
// Six or seven passes through the shared divider, and for operation 0 the year and month
// subtraction loop, set how long a request keeps the block busy; done is registered from
// the final state. Reset clears the sequencer and sets the base year to 1990. cfg_ready is
// low while a request is in progress.

module epoch_seconds_calendar_converter_top #(
    parameter int YEAR_SPAN = escc_pkg::YEAR_SPAN_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire escc_pkg::escc_req_t req,
    output logic                     done,
    output escc_pkg::escc_rsp_t      rsp,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [11:0]         cfg_data
);

    localparam int YW = $clog2(4096 + YEAR_SPAN);
    localparam int NW = $clog2(YEAR_SPAN + 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_B100    = 5'd1;
    localparam logic [4:0] S_B400    = 5'd2;
    localparam logic [4:0] S_Y100    = 5'd3;
    localparam logic [4:0] S_Y400    = 5'd4;
    localparam logic [4:0] S_STEP    = 5'd5;
    localparam logic [4:0] S_YPART   = 5'd6;
    localparam logic [4:0] S_MSUM    = 5'd7;
    localparam logic [4:0] S_MULT    = 5'd8;
    localparam logic [4:0] S_TIME    = 5'd9;
    localparam logic [4:0] S_DAYDIV  = 5'd10;
    localparam logic [4:0] S_HOURDIV = 5'd11;
    localparam logic [4:0] S_MINDIV  = 5'd12;
    localparam logic [4:0] S_WEEKDIV = 5'd13;
    localparam logic [4:0] S_YEAR    = 5'd14;
    localparam logic [4:0] S_MONTH   = 5'd15;
    localparam logic [4:0] S_DONE    = 5'd16;

    logic [4:0]  state_reg, state_next;
    logic        launched_reg, launched_next;
    logic        stepped_reg, stepped_next;
    logic        done_reg, done_next;
    logic [11:0] base_reg, base_next;
    logic [1:0]  op_reg, op_next;
    logic [11:0] y_reg, y_next;
    logic [3:0]  m_reg, m_next;
    logic [4:0]  d_reg, d_next;
    logic [4:0]  h_reg, h_next;
    logic [5:0]  mi_reg, mi_next;
    logic [5:0]  s_reg, s_next;
    logic [31:0] tot_reg, tot_next;
    logic [21:0] days_reg, days_next;
    logic [16:0] hms_reg, hms_next;
    logic [5:0]  q100_reg, q100_next;
    logic [6:0]  r100_reg, r100_next;
    logic [8:0]  r400_reg, r400_next;
    logic [10:0] lb_reg, lb_next;
    logic [10:0] ly_reg, ly_next;
    logic        leap_reg, leap_next;
    logic [3:0]  k_reg, k_next;
    logic [2:0]  wd_reg, wd_next;
    logic [16:0] left_reg, left_next;
    logic [YW-1:0] yy_reg, yy_next;
    logic [NW-1:0] n_reg, n_next;
    logic [6:0]  c100_reg, c100_next;
    logic [8:0]  c400_reg, c400_next;
    escc_pkg::escc_rsp_t rsp_reg, rsp_next;

    escc_pkg::div_cmd_t div_cmd;
    escc_pkg::div_rsp_t div_rsp;
    logic        div_go;
    logic        div_fire;

    logic [12:0] probe_val;
    logic [12:0] probe_c100;
    logic [12:0] probe_c400;
    logic [12:0] probe_q4;
    logic [10:0] probe_l;
    logic        probe_leap;
    logic        yy_leap;
    logic [8:0]  yy_days;
    logic [4:0]  md_cur;
    logic [4:0]  md_prev;
    logic [4:0]  md_year;
    logic [4:0]  md_sum;
    logic [31:0] days_ext;
    logic [4:0]  after_week;

    escc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    // Year probe: (Y + 99) / 100 and (Y + 399) / 400 give the leap count below Y
    // and, through their remainders, whether Y itself is a leap year.
    assign probe_val  = ((state_reg == S_B100) || (state_reg == S_B400)) ?
                        {1'b0, base_reg} : {1'b0, y_reg};
    assign probe_c100 = probe_val + 13'd99;
    assign probe_c400 = probe_val + 13'd399;
    assign probe_q4   = probe_val + 13'd3;
    assign probe_l    = probe_q4[12:2] - 11'(q100_reg) + 11'(div_rsp.quotient[3:0]);
    assign probe_leap = (probe_val[1:0] == 2'd0) &&
                        ((r100_reg != 7'd99) || (div_rsp.remainder[8:0] == 9'd399));

    // The year walk keeps (Y + 99) mod 100 and (Y + 399) mod 400 as running counters.
    assign yy_leap  = (yy_reg[1:0] == 2'd0) && ((c100_reg != 7'd99) || (c400_reg == 9'd399));
    assign yy_days  = yy_leap ? 9'd366 : 9'd365;
    assign md_cur   = escc_pkg::month_days(m_reg, leap_reg);
    assign md_prev  = escc_pkg::month_days(m_reg - 4'd1, leap_reg);
    assign md_year  = escc_pkg::month_days(m_reg, yy_leap);
    assign md_sum   = escc_pkg::month_days(k_reg, leap_reg);
    assign days_ext = {{10{days_reg[21]}}, days_reg};
    assign div_fire = launched_reg && div_rsp.done;
    assign after_week = (op_reg == escc_pkg::OP_TO_DATE) ? S_YEAR : S_DONE;

    always_comb
    begin
        div_cmd.go       = div_go;
        div_cmd.dividend = tot_reg;
        div_cmd.divisor  = escc_pkg::DAY_SECONDS;
        div_cmd.recip    = escc_pkg::DAY_RECIP;
        case (state_reg)
            S_B100, S_Y100:
            begin
                div_cmd.dividend = {19'd0, probe_c100};
                div_cmd.divisor  = escc_pkg::CENTURY;
                div_cmd.recip    = escc_pkg::CENTURY_RECIP;
            end
            S_B400, S_Y400:
            begin
                div_cmd.dividend = {19'd0, probe_c400};
                div_cmd.divisor  = escc_pkg::QUAD_CENTURY;
                div_cmd.recip    = escc_pkg::QUAD_CENTURY_RECIP;
            end
            S_HOURDIV:
            begin
                div_cmd.dividend = {15'd0, hms_reg};
                div_cmd.divisor  = escc_pkg::HOUR_SECONDS;
                div_cmd.recip    = escc_pkg::HOUR_RECIP;
            end
            S_MINDIV:
            begin
                div_cmd.dividend = {20'd0, hms_reg[11:0]};
                div_cmd.divisor  = escc_pkg::MIN_SECONDS;
                div_cmd.recip    = escc_pkg::MIN_RECIP;
            end
            S_WEEKDIV:
            begin
                div_cmd.dividend = {11'd0, days_reg[20:0]};
                div_cmd.divisor  = escc_pkg::WEEK_DAYS;
                div_cmd.recip    = escc_pkg::WEEK_RECIP;
            end
            default:
            begin
                div_cmd.dividend = tot_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        stepped_next = stepped_reg;
        done_next  = 1'b0;
        base_next  = (cfg_valid && cfg_ready) ? cfg_data : base_reg;
        op_next    = op_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        h_next     = h_reg;
        mi_next    = mi_reg;
        s_next     = s_reg;
        tot_next   = tot_reg;
        days_next  = days_reg;
        hms_next   = hms_reg;
        q100_next  = q100_reg;
        r100_next  = r100_reg;
        r400_next  = r400_reg;
        lb_next    = lb_reg;
        ly_next    = ly_reg;
        leap_next  = leap_reg;
        k_next     = k_reg;
        wd_next    = wd_reg;
        left_next  = left_reg;
        yy_next    = yy_reg;
        n_next     = n_reg;
        c100_next  = c100_reg;
        c400_next  = c400_reg;
        rsp_next   = rsp_reg;
        div_go     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = req.operation;
                    tot_next     = req.epoch_seconds;
                    y_next       = req.in_year;
                    m_next       = req.in_month;
                    d_next       = req.in_day;
                    h_next       = req.in_hour;
                    mi_next      = req.in_minute;
                    s_next       = req.in_second;
                    stepped_next = 1'b0;
                    state_next   = S_B100;
                end
            end
            S_B100, S_Y100:
            begin
                div_go = !launched_reg;
                if (div_fire)
                begin
                    q100_next  = div_rsp.quotient[5:0];
                    r100_next  = div_rsp.remainder[6:0];
                    state_next = (state_reg == S_B100) ? S_B400 : S_Y400;
                end
            end
            S_B400:
            begin
                div_go = !launched_reg;
                if (div_fire)
                begin
                    lb_next    = probe_l;
                    r400_next  = div_rsp.remainder[8:0];
                    state_next = (op_reg == escc_pkg::OP_TO_DATE) ? S_DAYDIV : S_Y100;
                end
            end
            S_Y400:
            begin
                div_go = !launched_reg;
                if (div_fire)
                begin
                    ly_next    = probe_l;
                    leap_next  = probe_leap;
                    state_next = stepped_reg ? S_YPART : S_STEP;
                end
            end
            S_STEP:
            begin
                stepped_next = 1'b1;
                state_next   = S_Y100;
                case (op_reg)
                    escc_pkg::OP_NEXT_DAY:
                    begin
                        if (d_reg < md_cur)
                        begin
                            d_next = d_reg + 5'd1;
                        end
                        else
                        begin
                            d_next = 5'd1;
                            if (m_reg < escc_pkg::LAST_MONTH)
                            begin
                                m_next = m_reg + 4'd1;
                            end
                            else
                            begin
                                m_next = 4'd1;
                                y_next = y_reg + 12'd1;
                            end
                        end
                    end
                    escc_pkg::OP_PREV_DAY:
                    begin
                        if (d_reg > 5'd1)
                        begin
                            d_next = d_reg - 5'd1;
                        end
                        else if (m_reg > 4'd1)
                        begin
                            m_next = m_reg - 4'd1;
                            d_next = md_prev;
                        end
                        else
                        begin
                            y_next = y_reg - 12'd1;
                            m_next = escc_pkg::LAST_MONTH;
                            d_next = 5'd31;
                        end
                    end
                    escc_pkg::OP_TO_SECS:
                    begin
                        d_next = d_reg;
                    end
                    default:
                    begin
                        d_next = d_reg;
                    end
                endcase
            end
            S_YPART:
            begin
                if (y_reg < base_reg)
                begin
                    days_next  = '0;
                    state_next = S_MULT;
                end
                else
                begin
                    days_next  = 22'(y_reg - base_reg) * 22'd365 + 22'(ly_reg) - 22'(lb_reg);
                    k_next     = 4'd1;
                    state_next = S_MSUM;
                end
            end
            S_MSUM:
            begin
                if (k_reg < m_reg)
                begin
                    days_next = days_reg + 22'(md_sum);
                    k_next    = k_reg + 4'd1;
                end
                else
                begin
                    days_next  = days_reg + 22'(d_reg) - 22'd1;
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                tot_next   = days_ext * 32'(escc_pkg::DAY_SECONDS);
                state_next = S_TIME;
            end
            S_TIME:
            begin
                tot_next   = tot_reg + 32'(h_reg) * 32'(escc_pkg::HOUR_SECONDS)
                           + 32'(mi_reg) * 32'(escc_pkg::MIN_SECONDS) + 32'(s_reg);
                state_next = S_WEEKDIV;
            end
            S_DAYDIV:
            begin
                div_go = !launched_reg;
                if (div_fire)
                begin
                    days_next  = 22'(div_rsp.quotient[15:0]);
                    hms_next   = div_rsp.remainder;
                    left_next  = {1'b0, div_rsp.quotient[15:0]} + 17'd1;
                    yy_next    = YW'(base_reg);
                    n_next     = NW'(1);
                    c100_next  = r100_reg;
                    c400_next  = r400_reg;
                    state_next = S_HOURDIV;
                end
            end
            S_HOURDIV:
            begin
                div_go = !launched_reg;
                if (div_fire)
                begin
                    h_next     = div_rsp.quotient[4:0];
                    hms_next   = div_rsp.remainder;
                    state_next = S_MINDIV;
                end
            end
            S_MINDIV:
            begin
                div_go = !launched_reg;
                if (div_fire)
                begin
                    mi_next    = div_rsp.quotient[5:0];
                    s_next     = div_rsp.remainder[5:0];
                    state_next = S_WEEKDIV;
                end
            end
            S_WEEKDIV:
            begin
                // A day count of minus one (day zero of January in the base year) is a Sunday-style 7.
                if (!launched_reg && (days_reg == '1))
                begin
                    wd_next    = 3'd7;
                    state_next = after_week;
                end
                else
                begin
                    div_go = !launched_reg;
                    if (div_fire)
                    begin
                        wd_next    = div_rsp.remainder[2:0] + 3'd1;
                        state_next = after_week;
                    end
                end
            end
            S_YEAR:
            begin
                if ((n_reg < NW'(YEAR_SPAN)) && (left_reg > 17'(yy_days)))
                begin
                    left_next = left_reg - 17'(yy_days);
                    yy_next   = yy_reg + YW'(1);
                    n_next    = n_reg + NW'(1);
                    c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
                else
                begin
                    m_next     = 4'd1;
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if ((m_reg < escc_pkg::LAST_MONTH) && (left_reg > 17'(md_year)))
                begin
                    left_next = left_reg - 17'(md_year);
                    m_next    = m_reg + 4'd1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                rsp_next.out_year      = y_reg;
                rsp_next.out_month     = m_reg;
                rsp_next.out_day       = d_reg;
                rsp_next.out_hour      = h_reg;
                rsp_next.out_minute    = mi_reg;
                rsp_next.out_second    = s_reg;
                rsp_next.total_seconds = tot_reg;
                rsp_next.weekday       = wd_reg;
                if (op_reg == escc_pkg::OP_TO_DATE)
                begin
                    rsp_next.out_year = yy_reg[11:0];
                    rsp_next.out_day  = left_reg[4:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        launched_next = div_fire ? 1'b0 : (div_go ? 1'b1 : launched_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
            stepped_reg  <= 1'b0;
            done_reg     <= 1'b0;
            base_reg     <= escc_pkg::BASE_YEAR_RST;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            stepped_reg  <= stepped_next;
            done_reg     <= done_next;
            base_reg     <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        y_reg    <= y_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        h_reg    <= h_next;
        mi_reg   <= mi_next;
        s_reg    <= s_next;
        tot_reg  <= tot_next;
        days_reg <= days_next;
        hms_reg  <= hms_next;
        q100_reg <= q100_next;
        r100_reg <= r100_next;
        r400_reg <= r400_next;
        lb_reg   <= lb_next;
        ly_reg   <= ly_next;
        leap_reg <= leap_next;
        k_reg    <= k_next;
        wd_reg   <= wd_next;
        left_reg <= left_next;
        yy_reg   <= yy_next;
        n_reg    <= n_next;
        c100_reg <= c100_next;
        c400_reg <= c400_next;
        rsp_reg  <= rsp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    `ESCC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not start work")
    `ESCC_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while still working")
    `ESCC_ASSERT_IMP(a_div_owned, div_rsp.done, launched_reg, "divider finished without a launch")
    `ESCC_ASSERT_IMP(a_weekday_range, done, rsp.weekday != 3'd0, "weekday out of range")
    `ESCC_ASSERT_IMP(a_month_range, done && (op_reg == escc_pkg::OP_TO_DATE), (rsp.out_month >= 4'd1) && (rsp.out_month <= 4'd12), "decoded month out of range")

endmodule

`default_nettype wire

@@ tb/escc_result_checker.sv @@
// Result checker for the epoch seconds calendar converter: tracks the base year register,
// predicts each request's result and compares it with what the block returns.
// Depends on escc_pkg for the request and result types.
`timescale 1ns / 1ps

module escc_result_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  escc_pkg::escc_req_t req,
    input  logic                done,
    input  escc_pkg::escc_rsp_t rsp,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [11:0]         cfg_data,
    output int                  mismatches,
    output int                  pending
);
    import escc_pkg::*;

    localparam int unsigned SECS_PER_DAY = 86400;

    escc_rsp_t   expected_q[$];
    logic [11:0] base_year;
    int          errors = 0;
    int          outstanding;

    assign mismatches = errors;
    assign pending    = outstanding;

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned year_length(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m < 1 || m > 12)
            return 1;
        return 30 + ((m + m / 8) % 2);
    endfunction

    function automatic int unsigned leaps_before(input int unsigned n);
        return (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
    endfunction

    function automatic int days_since_base(input int unsigned y, m, d, base);
        int n;
        if (y < base)
            return 0;
        n = int'(365 * (y - base) + leaps_before(y) - leaps_before(base));
        for (int unsigned k = 1; k < m; k++)
            n += int'(month_length(k, y));
        return n + int'(d) - 1;
    endfunction

    function automatic escc_rsp_t convert(input escc_req_t r, input logic [11:0] base);
        escc_rsp_t   o;
        int unsigned yy;
        int unsigned mm;
        int unsigned dd;
        int unsigned left;
        int unsigned rem;
        int unsigned span;
        int unsigned t;
        int          days;
        int          wd;
        o = '0;
        if (r.operation == OP_TO_DATE) begin
            rem  = r.epoch_seconds % SECS_PER_DAY;
            left = r.epoch_seconds / SECS_PER_DAY + 1;
            yy   = base;
            mm   = 1;
            span = 1;
            while (span < YEAR_SPAN_DEF && left > year_length(yy)) begin
                left -= year_length(yy);
                yy++;
                span++;
            end
            while (mm < LAST_MONTH && left > month_length(mm, yy)) begin
                left -= month_length(mm, yy);
                mm++;
            end
            o.out_year      = 12'(yy);
            o.out_month     = 4'(mm);
            o.out_day       = 5'(left);
            o.out_hour      = 5'(rem / 3600);
            o.out_minute    = 6'((rem % 3600) / 60);
            o.out_second    = 6'(rem % 60);
            o.total_seconds = r.epoch_seconds;
            o.weekday       = 3'((r.epoch_seconds / SECS_PER_DAY) % 7 + 1);
            return o;
        end
        yy = r.in_year;
        mm = r.in_month;
        dd = r.in_day;
        if (r.operation == OP_NEXT_DAY) begin
            if (dd < month_length(mm, yy)) begin
                dd++;
            end
            else begin
                dd = 1;
                if (mm < LAST_MONTH) begin
                    mm++;
                end
                else begin
                    mm = 1;
                    yy = (yy + 1) % 4096;
                end
            end
        end
        else if (r.operation == OP_PREV_DAY) begin
            if (dd > 1) begin
                dd--;
            end
            else if (mm > 1) begin
                mm--;
                dd = month_length(mm, yy);
            end
            else begin
                yy = (yy + 4095) % 4096;
                mm = LAST_MONTH;
                dd = 31;
            end
        end
        days = days_since_base(yy, mm, dd, base);
        t    = unsigned'(days) * SECS_PER_DAY + r.in_hour * 3600 + r.in_minute * 60
             + r.in_second;
        wd   = days % 7;
        if (wd < 0)
            wd += 7;
        o.out_year      = 12'(yy);
        o.out_month     = 4'(mm);
        o.out_day       = 5'(dd);
        o.out_hour      = r.in_hour;
        o.out_minute    = r.in_minute;
        o.out_second    = r.in_second;
        o.total_seconds = t;
        o.weekday       = 3'(wd + 1);
        return o;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        escc_rsp_t want;
        if (!rst_n) begin
            base_year <= BASE_YEAR_RST;
            expected_q.delete();
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                base_year <= cfg_data;
            if (start && !busy)
                expected_q.push_back(convert(req, base_year));
            if (done) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding: %0d-%0d-%0d",
                           rsp.out_year, rsp.out_month, rsp.out_day);
                    errors++;
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("out_year", want.out_year, rsp.out_year);
                    check_field("out_month", want.out_month, rsp.out_month);
                    check_field("out_day", want.out_day, rsp.out_day);
                    check_field("out_hour", want.out_hour, rsp.out_hour);
                    check_field("out_minute", want.out_minute, rsp.out_minute);
                    check_field("out_second", want.out_second, rsp.out_second);
                    check_field("total_seconds", want.total_seconds, rsp.total_seconds);
                    check_field("weekday", want.weekday, rsp.weekday);
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

@@ tb/tb_epoch_seconds_calendar_converter_top.sv @@
// Testbench top for the epoch seconds calendar converter: drives directed and random
// requests under several base years and gives the verdict.
// Depends on escc_pkg, the converter top level and escc_result_checker.
`timescale 1ns / 1ps

module tb_epoch_seconds_calendar_converter_top;
    import escc_pkg::*;

    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_PER_SET = 170;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    escc_req_t   req;
    logic        done;
    escc_rsp_t   rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;
    int          mismatches;
    int          pending;
    int          idle_cycles = 0;
    int          sent = 0;
    int          settings = 1;
    logic [11:0] cur_base;

    epoch_seconds_calendar_converter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    escc_result_checker calendar_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic escc_req_t item(input logic [1:0] op, input logic [31:0] secs,
                                       input logic [11:0] y, input logic [3:0] m,
                                       input logic [4:0] d, input logic [4:0] h,
                                       input logic [5:0] mi, input logic [5:0] s);
        escc_req_t r;
        r.operation     = op;
        r.epoch_seconds = secs;
        r.in_year       = y;
        r.in_month      = m;
        r.in_day        = d;
        r.in_hour       = h;
        r.in_minute     = mi;
        r.in_second     = s;
        return r;
    endfunction

    function automatic int pick_gap(input bit steady);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    function automatic escc_req_t random_request(input logic [11:0] base);
        escc_req_t   r;
        logic [95:0] noise;
        int unsigned roll;
        int unsigned pick;
        noise = {$urandom(), $urandom(), $urandom()};
        r = noise[71:0];
        r.operation = 2'($urandom_range(OP_TO_DATE, OP_PREV_DAY));
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 3);
        if (roll < 80) begin
            r.in_year   = 12'(int'(base) + int'($urandom_range(0, 150)) - 5);
            r.in_month  = 4'($urandom_range(1, LAST_MONTH));
            r.in_day    = (pick == 0) ? 5'd1 :
                          (pick == 1) ? 5'($urandom_range(28, 31)) :
                                        5'($urandom_range(1, 28));
            r.in_hour   = 5'($urandom_range(0, 23));
            r.in_minute = 6'($urandom_range(0, 59));
            r.in_second = 6'($urandom_range(0, 59));
        end
        if (roll < 20)
            r.epoch_seconds = $urandom_range(0, 86400 * 800);
        else if (roll < 30)
            r.epoch_seconds = 32'hFFFF_FFFF - $urandom_range(0, 86400 * 400);
        return r;
    endfunction

    task automatic send(input escc_req_t r, input int gap);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_base(input logic [11:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_base = value;
        settings++;
    endtask

    initial begin
        logic [11:0] bases [5];
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        cur_base  = BASE_YEAR_RST;
        bases     = '{12'd1900, 12'd2099, 12'd1970, 12'd0, 12'd1990};
        bases[3]  = 12'($urandom_range(1900, 2099));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(item(OP_TO_DATE, 32'd0, 12'd5, 4'd5, 5'd5, 5'd5, 6'd5, 6'd5), pick_gap(0));
        send(item(OP_TO_DATE, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0), pick_gap(0));
        send(item(OP_TO_DATE, 32'd86399, '1, '1, '1, '1, '1, '1), pick_gap(0));
        send(item(OP_TO_DATE, 32'h8000_0000, '0, '0, '0, '0, '0, '0), pick_gap(0));
        send(item(OP_TO_DATE, 32'd789 * 32'd86400 + 32'd3661, '0, '0, '0, '0, '0, '0),
             pick_gap(0));
        send(item(OP_TO_SECS, '0, 12'd0, 4'd5, 5'd10, 5'd23, 6'd59, 6'd59), pick_gap(0));
        send(item(OP_TO_SECS, '0, 12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59), pick_gap(0));
        send(item(OP_TO_SECS, '0, 12'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_TO_SECS, '0, 12'd1990, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_TO_SECS, '0, 12'd2024, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63), pick_gap(0));
        send(item(OP_TO_SECS, '1, 12'd2024, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63), pick_gap(0));
        send(item(OP_NEXT_DAY, '0, 12'd4095, 4'd12, 5'd31, 5'd1, 6'd2, 6'd3), pick_gap(0));
        send(item(OP_NEXT_DAY, '0, 12'd2000, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_NEXT_DAY, '0, 12'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_NEXT_DAY, '0, 12'd1900, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_NEXT_DAY, '0, 12'd2023, 4'd13, 5'd1, 5'd9, 6'd9, 6'd9), pick_gap(0));
        send(item(OP_NEXT_DAY, '0, 12'd2023, 4'd0, 5'd5, 5'd9, 6'd9, 6'd9), pick_gap(0));
        send(item(OP_NEXT_DAY, '0, 12'd2023, 4'd6, 5'd15, 5'd9, 6'd9, 6'd9), pick_gap(0));
        send(item(OP_PREV_DAY, '0, 12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_PREV_DAY, '0, 12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_PREV_DAY, '0, 12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_PREV_DAY, '0, 12'd2023, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_PREV_DAY, '0, 12'd2023, 4'd15, 5'd1, 5'd0, 6'd0, 6'd0), pick_gap(0));
        send(item(OP_PREV_DAY, '0, 12'd2023, 4'd8, 5'd31, 5'd0, 6'd0, 6'd0), pick_gap(0));

        foreach (bases[b]) begin
            write_base(bases[b]);
            send(item(OP_TO_DATE, 32'd0, '0, '0, '0, '0, '0, '0), pick_gap(0));
            send(item(OP_TO_DATE, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0), pick_gap(0));
            for (int i = 0; i < RANDOM_PER_SET; i++)
                send(random_request(cur_base), pick_gap((i / 30) % 4 == 3));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d conversion requests over %0d base year settings,", sent, settings);
        $display("covering all four operations and the calendar edge cases.");
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/escc_pkg.sv
src/escc_div.sv
src/epoch_seconds_calendar_converter_top.sv
tb/escc_result_checker.sv
tb/tb_epoch_seconds_calendar_converter_top.sv
